// File: rtl/slt_pkg.sv
// shared types and constants for the structured light triangulation core
// no dependencies
package slt_pkg;

  localparam int MAX_FRAME_DIM = 4096;
  localparam int DIM_W         = $clog2(MAX_FRAME_DIM) + 1;
  localparam int CNT_W         = $clog2(MAX_FRAME_DIM);
  localparam int COEF_W        = 40;
  localparam int IDX_W         = 5;
  localparam int TABLE_DEPTH   = 24;
  localparam int PC_W          = 16;
  localparam int OUT_W         = 32;
  localparam int ENT_W         = 60;
  localparam int PROD_W        = 2 * ENT_W;
  localparam int MINOR_W       = PROD_W + 1;
  localparam int DET_W         = 184;
  localparam int MAG_W         = 224;
  localparam int QUO_W         = OUT_W + 1;
  localparam int DIV_STAGES    = QUO_W + 2;
  localparam int LIMB_W        = 30;
  localparam int ENT_LIMBS     = 2;
  localparam int MN_LIMBS      = 5;
  localparam int DET_STAGES    = 7;
  localparam int PIPE_DEPTH    = 1 + DET_STAGES + DIV_STAGES;

  localparam logic [0:0] ACT_LOAD  = 1'b0;
  localparam logic [0:0] ACT_PIXEL = 1'b1;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [ENT_W-1:0]   ent_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [MINOR_W-1:0] minor_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic signed [LIMB_W:0]    limb_t;
  typedef logic signed [2*LIMB_W+1:0] pp_t;
  typedef logic signed [MN_LIMBS*LIMB_W-1:0] mnx_t;

  typedef struct packed {
    logic [CNT_W-1:0] cam_x;
    logic [CNT_W-1:0] cam_y;
    logic             singular;
  } meta_t;

endpackage

// File: rtl/slt_det.sv
// pipelined exact 3x3 determinant, seven register stages
// wide products are split into 31-bit signed limbs; depends on slt_pkg
module slt_det (
  input  logic          clk_i,
  input  logic          en_i,
  input  slt_pkg::ent_t m_i [3][3],
  output slt_pkg::det_t det_o
);
  import slt_pkg::*;

  ent_t   pa [6];
  ent_t   pb [6];
  pp_t    pp1_q [6][ENT_LIMBS][ENT_LIMBS];
  prod_t  psum [6];
  prod_t  p_q [6];
  ent_t   r0a_q [3];
  ent_t   r0b_q [3];
  ent_t   r0c_q [3];
  minor_t mn_q [3];
  pp_t    pp2_q [3][ENT_LIMBS][MN_LIMBS];
  det_t   ssum [3][ENT_LIMBS];
  det_t   s_q [3][ENT_LIMBS];
  det_t   t_q [3];
  det_t   det_q;

  // low limbs are zero extended, the top limb carries the sign
  function automatic limb_t ent_limb(ent_t v, int i);
    if (i == ENT_LIMBS - 1) return limb_t'($signed(v[i*LIMB_W +: LIMB_W]));
    return limb_t'({1'b0, v[i*LIMB_W +: LIMB_W]});
  endfunction

  function automatic limb_t mn_limb(minor_t v, int j);
    mnx_t x;
    x = mnx_t'(v);
    if (j == MN_LIMBS - 1) return limb_t'($signed(x[j*LIMB_W +: LIMB_W]));
    return limb_t'({1'b0, x[j*LIMB_W +: LIMB_W]});
  endfunction

  // row 1 times row 2 cross products
  always_comb begin
    pa[0] = m_i[1][1]; pb[0] = m_i[2][2];
    pa[1] = m_i[1][2]; pb[1] = m_i[2][1];
    pa[2] = m_i[1][0]; pb[2] = m_i[2][2];
    pa[3] = m_i[1][2]; pb[3] = m_i[2][0];
    pa[4] = m_i[1][0]; pb[4] = m_i[2][1];
    pa[5] = m_i[1][1]; pb[5] = m_i[2][0];
  end

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      psum[p] = '0;
      for (int i = 0; i < ENT_LIMBS; i++) begin
        for (int j = 0; j < ENT_LIMBS; j++) begin
          psum[p] = psum[p] + (prod_t'(pp1_q[p][i][j]) <<< (LIMB_W * (i + j)));
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < ENT_LIMBS; i++) begin
        ssum[c][i] = '0;
        for (int j = 0; j < MN_LIMBS; j++) begin
          ssum[c][i] = ssum[c][i] + (det_t'(pp2_q[c][i][j]) <<< (LIMB_W * j));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < 6; p++) begin
        for (int i = 0; i < ENT_LIMBS; i++) begin
          for (int j = 0; j < ENT_LIMBS; j++) begin
            pp1_q[p][i][j] <= pp_t'(ent_limb(pa[p], i)) * pp_t'(ent_limb(pb[p], j));
          end
        end
        p_q[p] <= psum[p];
      end
      for (int c = 0; c < 3; c++) begin
        r0a_q[c] <= m_i[0][c];
        r0b_q[c] <= r0a_q[c];
        r0c_q[c] <= r0b_q[c];
      end
      mn_q[0] <= minor_t'(p_q[0]) - minor_t'(p_q[1]);
      mn_q[1] <= minor_t'(p_q[2]) - minor_t'(p_q[3]);
      mn_q[2] <= minor_t'(p_q[4]) - minor_t'(p_q[5]);
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < ENT_LIMBS; i++) begin
          for (int j = 0; j < MN_LIMBS; j++) begin
            pp2_q[c][i][j] <= pp_t'(ent_limb(r0c_q[c], i)) * pp_t'(mn_limb(mn_q[c], j));
          end
          s_q[c][i] <= ssum[c][i];
        end
        t_q[c] <= s_q[c][0] + (s_q[c][1] <<< LIMB_W);
      end
      det_q <= t_q[0] - t_q[1] + t_q[2];
    end
  end

  assign det_o = det_q;

endmodule

// File: rtl/slt_div.sv
// pipelined restoring divider: round(n/d) to nearest, saturated to 32 bits
// three numerators share one divisor; depends on slt_pkg
module slt_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  slt_pkg::mag_t            n_i [3],
  input  logic [2:0]               neg_i,
  input  slt_pkg::mag_t            d_i,
  output logic signed [31:0]       res_o [3]
);
  import slt_pkg::*;

  mag_t             d_q   [QUO_W+1];
  mag_t             rem_q [3][QUO_W+1];
  logic [QUO_W-1:0] quo_q [3][QUO_W+1];
  logic [2:0]       neg_q [QUO_W+1];
  logic signed [OUT_W-1:0] res_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]   <= d_i;
      neg_q[0] <= neg_i;
      for (int k = 0; k < 3; k++) begin
        rem_q[k][0] <= n_i[k];
        quo_q[k][0] <= '0;
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    mag_t dsh;
    assign dsh = d_q[j-1] << (QUO_W - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j]   <= d_q[j-1];
        neg_q[j] <= neg_q[j-1];
        for (int k = 0; k < 3; k++) begin
          if (rem_q[k][j-1] >= dsh) begin
            rem_q[k][j] <= rem_q[k][j-1] - dsh;
            quo_q[k][j] <= {quo_q[k][j-1][QUO_W-2:0], 1'b1};
          end else begin
            rem_q[k][j] <= rem_q[k][j-1];
            quo_q[k][j] <= {quo_q[k][j-1][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_round
    logic             up;
    logic [QUO_W:0]   qr;
    logic             big;
    logic [OUT_W-1:0] lim;
    logic [OUT_W-1:0] mag;
    always_comb begin
      up  = (rem_q[k][QUO_W] << 1) >= d_q[QUO_W];
      qr  = {1'b0, quo_q[k][QUO_W]} + (QUO_W+1)'(up);
      big = qr[QUO_W] | qr[QUO_W-1];
      lim = neg_q[QUO_W][k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag = (big || (qr[OUT_W-1:0] > lim)) ? lim : qr[OUT_W-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[k] <= neg_q[QUO_W][k] ? -$signed(mag) : $signed(mag);
      end
    end
    assign res_o[k] = res_q[k];
  end

endmodule

// File: rtl/structured_light_triangulation_core.sv
// structured light triangulation core: one item per cycle sustained while the output is
// not stalled; the depth is set by the 33-step restoring divider
// and the seven-stage determinant pipeline. a stall at the output freezes every stage.
// reset (async, active low) clears valid bits and raster counters, width 640, height 480;
// the coefficient table is not reset and must be loaded before pixels arrive
module structured_light_triangulation_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [12:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [0:0]                  action_i,
  input  logic [4:0]                  coef_index_i,
  input  logic signed [39:0]          coef_value_i,
  input  logic                        mask_bit_i,
  input  logic [15:0]                 proj_coord_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [11:0]                 cam_x_o,
  output logic [11:0]                 cam_y_o,
  output logic signed [31:0]          point_x_o,
  output logic signed [31:0]          point_y_o,
  output logic signed [31:0]          point_z_o,
  output logic                        singular_o
);
  import slt_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] width_eff, height_eff;
  logic [CNT_W-1:0] col_q, row_q;
  coef_t            tbl_q [TABLE_DEPTH];
  logic [PIPE_DEPTH-1:0] vld_q;
  meta_t            meta_q [PIPE_DEPTH];
  ent_t             q_q [3][3];
  ent_t             f_q [3];
  ent_t             mat [4][3][3];
  det_t             det [4];
  mag_t             num [3];
  mag_t             den;
  logic [2:0]       neg;
  logic signed [OUT_W-1:0] res [3];
  logic             adv, acc, pix, keep;
  ent_t             xe, ye, ue;

  assign adv        = !(vld_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;
  assign pix        = acc && (action_i == ACT_PIXEL);
  assign keep       = pix && mask_bit_i && (proj_coord_i != '0);

  always_comb begin
    width_eff  = (width_q == '0) ? DIM_W'(1) :
                 (width_q > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : width_q;
    height_eff = (height_q == '0) ? DIM_W'(1) :
                 (height_q > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix) begin
      if ({1'b0, col_q} + DIM_W'(1) >= width_eff) begin
        col_q <= '0;
        if ({1'b0, row_q} + DIM_W'(1) >= height_eff) row_q <= '0;
        else row_q <= row_q + CNT_W'(1);
      end else begin
        col_q <= col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (action_i == ACT_LOAD) && (coef_index_i < IDX_W'(TABLE_DEPTH))) begin
      tbl_q[coef_index_i] <= coef_value_i;
    end
  end

  // entry stage: form the linear system from the current table
  assign xe = ent_t'(signed'({1'b0, col_q}));
  assign ye = ent_t'(signed'({1'b0, row_q}));
  assign ue = ent_t'(signed'({1'b0, proj_coord_i}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        q_q[0][c] <= ent_t'(tbl_q[c]) - xe * ent_t'(tbl_q[8+c]);
        q_q[1][c] <= ent_t'(tbl_q[4+c]) - ye * ent_t'(tbl_q[8+c]);
        q_q[2][c] <= (ent_t'(tbl_q[12+c]) <<< 4) - ue * ent_t'(tbl_q[20+c]);
      end
      f_q[0] <= xe * ent_t'(tbl_q[11]) - ent_t'(tbl_q[3]);
      f_q[1] <= ye * ent_t'(tbl_q[11]) - ent_t'(tbl_q[7]);
      f_q[2] <= ue * ent_t'(tbl_q[23]) - (ent_t'(tbl_q[15]) <<< 4);
    end
  end

  // cramer matrices: column k swapped for the right-hand side, last one plain
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat[k][r][c] = (c == k) ? f_q[r] : q_q[r][c];
        end
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_det
    slt_det u_det (
      .clk_i (clk_i),
      .en_i  (adv),
      .m_i   (mat[k]),
      .det_o (det[k])
    );
  end

  always_comb begin
    det_t a;
    a   = det[3][DET_W-1] ? -det[3] : det[3];
    den = mag_t'($unsigned(a));
    for (int k = 0; k < 3; k++) begin
      a      = det[k][DET_W-1] ? -det[k] : det[k];
      num[k] = mag_t'($unsigned(a)) << 8;
      neg[k] = det[k][DET_W-1] ^ det[3][DET_W-1];
    end
  end

  slt_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .n_i   (num),
    .neg_i (neg),
    .d_i   (den),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], keep};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= '{cam_x: col_q, cam_y: row_q, singular: 1'b0};
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (i == DET_STAGES + 1) begin
          // determinant is final at the divider's input stage
          meta_q[i] <= '{cam_x: meta_q[i-1].cam_x, cam_y: meta_q[i-1].cam_y,
                         singular: (det[3] == '0)};
        end else begin
          meta_q[i] <= meta_q[i-1];
        end
      end
    end
  end

  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign cam_x_o     = meta_q[PIPE_DEPTH-1].cam_x;
  assign cam_y_o     = meta_q[PIPE_DEPTH-1].cam_y;
  assign singular_o  = meta_q[PIPE_DEPTH-1].singular;
  assign point_x_o   = singular_o ? '0 : res[0];
  assign point_y_o   = singular_o ? '0 : res[1];
  assign point_z_o   = singular_o ? '0 : res[2];

endmodule

// File: rtl/slt_checker.sv
// port-level checks for the structured light triangulation core
// bound to the top level; depends on nothing else
module slt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] point_x_o,
  input logic signed [31:0] point_y_o,
  input logic signed [31:0] point_z_o,
  input logic               singular_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(point_x_o) && $stable(point_y_o)
      && $stable(point_z_o) && $stable(singular_o))
    else $error("stalled result changed");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> point_x_o == 0 && point_y_o == 0 && point_z_o == 0)
    else $error("singular item with nonzero point");

  a_stall_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to output backpressure");

endmodule

bind structured_light_triangulation_core slt_checker u_slt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .point_x_o   (point_x_o),
  .point_y_o   (point_y_o),
  .point_z_o   (point_z_o),
  .singular_o  (singular_o)
);

// File: test/tb_structured_light_triangulation_core.sv
// testbench for the structured light triangulation core: loads projection matrices,
// streams raster pixels and checks each reconstructed point against a local predictor
// depends on rtl/slt_pkg.sv and rtl/structured_light_triangulation_core.sv
`timescale 1ns / 1ps

module tb_structured_light_triangulation_core;
  import slt_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = PIPE_DEPTH + 8;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [11:0]        cam_x;
    logic [11:0]        cam_y;
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
    logic               singular;
  } point_rec_t;

  class tri_scoreboard;
    logic signed [39:0] coef_tab[TABLE_DEPTH];
    int unsigned col, row, width, height;
    point_rec_t pending[$];
    wide_t mat[3][3];
    int errors;

    function new();
      col = 0; row = 0; width = 640; height = 480; errors = 0;
      foreach (coef_tab[i]) coef_tab[i] = '0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [12:0] val);
      int unsigned v;
      v = (val == 0) ? 1 : (val > MAX_FRAME_DIM) ? MAX_FRAME_DIM : val;
      if (idx == REG_WIDTH) width = v;
      else height = v;
    endfunction

    function wide_t det_of_mat();
      wide_t a, b, c;
      a = mat[1][1] * mat[2][2] - mat[1][2] * mat[2][1];
      b = mat[1][0] * mat[2][2] - mat[1][2] * mat[2][0];
      c = mat[1][0] * mat[2][1] - mat[1][1] * mat[2][0];
      return mat[0][0] * a - mat[0][1] * b + mat[0][2] * c;
    endfunction

    // 256*num/den, round half away from zero, saturate to 32 bits
    function logic [31:0] scaled_div(wide_t num, wide_t den);
      logic neg;
      wide_t n;
      logic [255:0] un, ud, q, r;
      logic [31:0] lim, mag;
      neg = num[255] ^ den[255];
      n = num * 256;
      un = n[255] ? -n : n;
      ud = den[255] ? -den : den;
      q = un / ud;
      r = un % ud;
      if ((r << 1) >= ud) q = q + 1;
      lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      mag = (q > lim) ? lim : q[31:0];
      return neg ? -mag : mag;
    endfunction

    function void note_input(logic [0:0] act, logic [4:0] idx, logic signed [39:0] val,
                             logic msk, logic [15:0] u);
      int unsigned x, y;
      wide_t wx, wy, wu, q[3][3], f[3], d;
      wide_t cm[12], pm[12];
      logic [31:0] res[3];
      point_rec_t rec;
      if (act == ACT_LOAD) begin
        if (idx < TABLE_DEPTH) coef_tab[idx] = val;
        return;
      end
      x = col; y = row;
      if (col + 1 >= width) begin
        col = 0;
        if (row + 1 >= height) row = 0;
        else row = row + 1;
      end else begin
        col = col + 1;
      end
      if (!msk || u == 0) return;
      for (int i = 0; i < 12; i++) begin
        cm[i] = wide_t'(coef_tab[i]);
        pm[i] = wide_t'(coef_tab[12 + i]);
      end
      wx = wide_t'(x); wy = wide_t'(y); wu = wide_t'(u);
      for (int c = 0; c < 3; c++) begin
        q[0][c] = cm[c] - wx * cm[8 + c];
        q[1][c] = cm[4 + c] - wy * cm[8 + c];
        q[2][c] = pm[c] * 16 - wu * pm[8 + c];
      end
      f[0] = wx * cm[11] - cm[3];
      f[1] = wy * cm[11] - cm[7];
      f[2] = wu * pm[11] - pm[3] * 16;
      mat = q;
      d = det_of_mat();
      rec.cam_x = x[11:0];
      rec.cam_y = y[11:0];
      if (d == 0) begin
        rec.pt_x = 0; rec.pt_y = 0; rec.pt_z = 0; rec.singular = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) begin
          for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
              mat[r][c] = (c == k) ? f[r] : q[r][c];
          res[k] = scaled_div(det_of_mat(), d);
        end
        rec.pt_x = res[0]; rec.pt_y = res[1]; rec.pt_z = res[2]; rec.singular = 1'b0;
      end
      pending.push_back(rec);
    endfunction

    function void check_point(point_rec_t got);
      point_rec_t exp_rec;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected point at (%0d,%0d)", $realtime, got.cam_x, got.cam_y);
        return;
      end
      exp_rec = pending.pop_front();
      if (got.cam_x !== exp_rec.cam_x) begin
        errors++;
        $display("%0t: cam_x exp %0d got %0d", $realtime, exp_rec.cam_x, got.cam_x);
      end
      if (got.cam_y !== exp_rec.cam_y) begin
        errors++;
        $display("%0t: cam_y exp %0d got %0d", $realtime, exp_rec.cam_y, got.cam_y);
      end
      if (got.pt_x !== exp_rec.pt_x) begin
        errors++;
        $display("%0t: point_x exp %0d got %0d", $realtime, exp_rec.pt_x, got.pt_x);
      end
      if (got.pt_y !== exp_rec.pt_y) begin
        errors++;
        $display("%0t: point_y exp %0d got %0d", $realtime, exp_rec.pt_y, got.pt_y);
      end
      if (got.pt_z !== exp_rec.pt_z) begin
        errors++;
        $display("%0t: point_z exp %0d got %0d", $realtime, exp_rec.pt_z, got.pt_z);
      end
      if (got.singular !== exp_rec.singular) begin
        errors++;
        $display("%0t: singular exp %0d got %0d", $realtime, exp_rec.singular, got.singular);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [12:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [0:0]         action;
  logic [4:0]         coef_index;
  logic signed [39:0] coef_value;
  logic               mask_bit;
  logic [15:0]        proj_coord;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        cam_x, cam_y;
  logic signed [31:0] point_x, point_y, point_z;
  logic               singular;

  tri_scoreboard sb;
  bit            quiet;
  int            stall_left;
  int            idle_cycles;
  bit            take_out;
  point_rec_t    seen;

  structured_light_triangulation_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .coef_index_i (coef_index),
    .coef_value_i (coef_value),
    .mask_bit_i   (mask_bit),
    .proj_coord_i (proj_coord),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .cam_x_o      (cam_x),
    .cam_y_o      (cam_y),
    .point_x_o    (point_x),
    .point_y_o    (point_y),
    .point_z_o    (point_z),
    .singular_o   (singular)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall pattern
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= gap_len();
      out_stall <= 1'b0;
    end
  end

  // sample mid-cycle so the check does not race the block's own updates
  always @(negedge clk) begin
    take_out = rst_n && out_valid && !out_stall;
    seen = '{cam_x, cam_y, point_x, point_y, point_z, singular};
    if ((in_valid && !in_stall) || take_out) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_structured_light_triangulation_core: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (take_out) sb.check_point(seen);
  end

  task automatic push(logic [0:0] act, logic [4:0] idx, logic signed [39:0] val,
                      logic msk, logic [15:0] u);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    action <= act; coef_index <= idx; coef_value <= val;
    mask_bit <= msk; proj_coord <= u; in_valid <= 1'b1;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_input(act, idx, val, msk, u);
  endtask

  task automatic load(logic [4:0] idx, logic signed [39:0] val);
    push(ACT_LOAD, idx, val, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  task automatic pixel(logic msk, logic [15:0] u);
    push(ACT_PIXEL, 5'($urandom), 40'({$urandom, $urandom}), msk, u);
  endtask

  // hold off until the pipeline is empty, then let it settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(logic [12:0] w, logic [12:0] h);
    in_valid <= 1'b0;
    cfg_we <= 1'b1; cfg_index <= REG_WIDTH; cfg_wdata <= w;
    @(posedge clk);
    sb.write_reg(REG_WIDTH, w);
    cfg_index <= REG_HEIGHT; cfg_wdata <= h;
    @(posedge clk);
    sb.write_reg(REG_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [39:0] rand_coef();
    logic [63:0] v;
    int k;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? 40'sh80_0000_0000 : 40'sh7f_ffff_ffff;
      default: begin
        k = $urandom_range(1, 39);
        v = {$urandom, $urandom} & ((64'd1 << k) - 1);
        return $urandom_range(0, 1) ? -$signed(v[39:0]) : $signed(v[39:0]);
      end
    endcase
  endfunction

  task automatic load_pinhole(bit flat_proj);
    logic signed [39:0] m[TABLE_DEPTH];
    foreach (m[i]) m[i] = '0;
    m[0] = 40'sd800 << 16; m[2] = 40'sd320 << 16;
    m[5] = 40'sd800 << 16; m[6] = 40'sd240 << 16; m[10] = 40'sd1 << 16;
    if (!flat_proj) begin
      m[12] = 40'sd1000 << 16; m[14] = 40'sd512 << 16; m[15] = -(40'sd200 << 16);
      m[17] = 40'sd1000 << 16; m[18] = 40'sd384 << 16; m[22] = 40'sd1 << 16;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) load(5'(i), m[i]);
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        load(5'($urandom_range(0, 31)), rand_coef());
      end else begin
        case ($urandom_range(0, 9))
          0: pixel(1'b0, 16'($urandom));
          1: pixel(1'b1, '0);
          2: pixel(1'b1, $urandom_range(0, 1) ? 16'hffff : 16'h0001);
          default: pixel(1'b1, 16'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_WIDTH; cfg_wdata = '0;
    in_valid = 1'b0; action = ACT_LOAD; coef_index = '0; coef_value = '0;
    mask_bit = 1'b0; proj_coord = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_size(13'd8, 13'd4);
    // directed: plausible rig, rejected pixels, column extremes, ignored slots
    load_pinhole(1'b0);
    load(5'd24, 40'sh7f_ffff_ffff);
    load(5'd31, 40'sh80_0000_0000);
    pixel(1'b0, 16'h1234);
    pixel(1'b1, 16'h0000);
    pixel(1'b1, 16'h0001);
    pixel(1'b1, 16'hffff);
    pixel(1'b1, 16'h2000);
    load(5'd0, 40'sh80_0000_0000);
    load(5'd11, 40'sh7f_ffff_ffff);
    pixel(1'b1, 16'h8000);
    pixel(1'b1, 16'h5555);
    drain();
    // projector rows zeroed: every solve is singular
    load_pinhole(1'b1);
    pixel(1'b1, 16'h0100);
    pixel(1'b1, 16'haaaa);
    drain();

    for (int i = 0; i < TABLE_DEPTH; i++) load(5'(i), rand_coef());
    set_size(13'd5, 13'd3);
    random_run(600);
    drain();

    quiet = 1'b1;
    set_size(13'd0, 13'h1fff);
    random_run(40);
    drain();
    set_size(13'd4096, 13'd1);
    random_run(40);
    drain();
    quiet = 1'b0;

    load_pinhole(1'b0);
    set_size(13'd640, 13'd480);
    random_run(600);
    drain();
    quiet = 1'b1;
    set_size(13'd1, 13'd4095);
    random_run(300);
    drain();
    quiet = 1'b0;
    set_size(13'd3, 13'd2);
    random_run(300);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_structured_light_triangulation_core: clean");
    else
      $display("tb_structured_light_triangulation_core: errors");
    $finish;
  end

endmodule

// File: structured_light_triangulation_core.f
rtl/slt_pkg.sv
rtl/slt_det.sv
rtl/slt_div.sv
rtl/structured_light_triangulation_core.sv
rtl/slt_checker.sv
test/tb_structured_light_triangulation_core.sv
